@@ rtl/core/ptd_pkg.sv @@
package ptd_pkg;

	localparam int MAX_TASKS_DEF  = 16;
	localparam int TICK_WIDTH_DEF = 16;

	localparam logic [2:0] FN_TICK   = 3'd0;
	localparam logic [2:0] FN_ADD    = 3'd1;
	localparam logic [2:0] FN_RESET  = 3'd2;
	localparam logic [2:0] FN_POLL   = 3'd3;
	localparam logic [2:0] FN_REMOVE = 3'd4;
	localparam logic [2:0] FN_SLEEP  = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NONE_DUE  = 2'd2;
	localparam logic [1:0] ST_BAD_INDEX = 2'd3;

	typedef struct packed {
		logic [2:0]  func;
		logic [3:0]  task_index;
		logic [14:0] tick_count;
	} ptd_in_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        dispatched;
		logic [3:0]  run_index;
		logic        woke_from_sleep;
		logic [4:0]  task_total;
		logic [31:0] elapsed_ticks;
	} ptd_out_t;

	typedef struct packed {
		logic load;
		logic init;
		logic apply;
		logic run;
	} ptd_ctl_t;

	typedef struct packed {
		logic [2:0] func;
		logic       idx_bad;
		logic       drained;
		logic       hit;
	} ptd_sts_t;

endpackage

@@ rtl/core/ptd_ctrl.sv @@
module ptd_ctrl
	import ptd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  ptd_sts_t sts,
	output ptd_ctl_t ctl,
	output logic     busy,
	output logic     done
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DISPATCH,
		S_SWEEP
	} state_t;

	state_t state_q;
	logic   busy_q;
	logic   done_q;
	logic   sweep_op;

	always_comb begin
		sweep_op = (sts.func inside {FN_TICK, FN_POLL}) ||
			(sts.func == FN_REMOVE && !sts.idx_bad);
		ctl.load  = (state_q == S_IDLE) && start;
		ctl.init  = (state_q == S_DISPATCH) && sweep_op;
		ctl.apply = (state_q == S_DISPATCH) && !sweep_op;
		ctl.run   = (state_q == S_SWEEP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						busy_q  <= 1'b1;
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					if (sweep_op) begin
						state_q <= S_SWEEP;
					end else begin
						busy_q  <= 1'b0;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_SWEEP: begin
					if (sts.hit || sts.drained) begin
						busy_q  <= 1'b0;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					busy_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = busy_q;
	assign done = done_q;

endmodule

@@ rtl/core/ptd_dp.sv @@
module ptd_dp
	import ptd_pkg::*;
#(
	parameter int MAX_TASKS  = MAX_TASKS_DEF,
	parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  ptd_in_t  request,
	input  ptd_ctl_t ctl,
	output ptd_sts_t sts,
	output ptd_out_t result
);

	localparam int IW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW   = $clog2(MAX_TASKS + 1);
	localparam int CMPW = CW + 4;
	localparam int DW   = (TICK_WIDTH > 15) ? TICK_WIDTH : 15;

	// task tables
	logic [14:0]           iv_mem [MAX_TASKS];
	logic [TICK_WIDTH-1:0] wt_mem [MAX_TASKS];
	logic [14:0]           sl_mem [MAX_TASKS];

	ptd_in_t               req_q;
	logic [CW-1:0]         total_q;
	logic [IW-1:0]         scan_q;
	logic [31:0]           ticks_q;
	logic [IW-1:0]         rd_q;
	logic [CW-1:0]         rem_q;
	logic                  v_s1;
	logic [IW-1:0]         addr_s1;
	logic [14:0]           iv_s1;
	logic [TICK_WIDTH-1:0] wt_s1;
	logic [14:0]           sl_s1;
	logic [1:0]            res_status_q;
	logic                  res_disp_q;
	logic [3:0]            res_index_q;
	logic                  res_woke_q;

	logic [CMPW-1:0]       idx_c;
	logic [CMPW-1:0]       total_c;
	logic                  idx_bad;
	logic                  full;
	logic                  due;
	logic                  hit;
	logic                  drained;
	logic                  rd_en;
	logic [IW-1:0]         rd_nxt;
	logic [IW-1:0]         scan_start;
	logic [IW-1:0]         scan_hit;
	logic [IW-1:0]         scan_dec;
	logic [CW-1:0]         tot_m1;

	logic                  iv_we;
	logic                  wt_we;
	logic                  sl_we;
	logic [IW-1:0]         wa;
	logic [14:0]           iv_wd;
	logic [TICK_WIDTH-1:0] wt_wd;
	logic [14:0]           sl_wd;

	always_comb begin
		idx_c      = CMPW'(req_q.task_index);
		total_c    = CMPW'(total_q);
		idx_bad    = idx_c >= total_c;
		full       = total_q == CW'(MAX_TASKS);
		due        = DW'(wt_s1) >= DW'(sl_s1) && DW'(wt_s1) >= DW'(iv_s1);
		hit        = v_s1 && req_q.func == FN_POLL && due;
		drained    = (rem_q == '0) && !v_s1;
		rd_en      = ctl.run && (rem_q != '0);
		rd_nxt     = ((CMPW'(rd_q) + CMPW'(1)) < total_c) ? rd_q + 1'b1 : '0;
		scan_start = (CMPW'(scan_q) < total_c) ? scan_q : '0;
		scan_hit   = ((CMPW'(addr_s1) + CMPW'(1)) < total_c) ? addr_s1 + 1'b1 : '0;
		scan_dec   = (CMPW'(scan_q) > idx_c) ? scan_q - 1'b1 : scan_q;
		tot_m1     = total_q - 1'b1;
	end

	assign sts.func    = req_q.func;
	assign sts.idx_bad = idx_bad;
	assign sts.drained = drained;
	assign sts.hit     = hit;

	always_comb begin
		iv_we = 1'b0;
		wt_we = 1'b0;
		sl_we = 1'b0;
		wa    = addr_s1;
		iv_wd = iv_s1;
		wt_wd = '0;
		sl_wd = '0;
		if (ctl.apply) begin
			case (req_q.func)
				FN_ADD: begin
					wa    = IW'(total_q);
					iv_wd = req_q.tick_count;
					iv_we = !full;
					wt_we = !full;
					sl_we = !full;
				end
				FN_RESET: begin
					wa    = IW'(req_q.task_index);
					wt_we = !idx_bad;
				end
				FN_SLEEP: begin
					wa    = IW'(req_q.task_index);
					sl_wd = req_q.tick_count;
					wt_we = !idx_bad;
					sl_we = !idx_bad;
				end
				default: ;
			endcase
		end else if (ctl.run && v_s1) begin
			case (req_q.func)
				FN_TICK: begin
					wt_wd = (wt_s1 == '1) ? wt_s1 : wt_s1 + 1'b1;
					wt_we = 1'b1;
				end
				FN_POLL: begin
					wt_we = due;
					sl_we = due;
				end
				FN_REMOVE: begin
					wa    = addr_s1 - 1'b1;
					wt_wd = wt_s1;
					sl_wd = sl_s1;
					iv_we = 1'b1;
					wt_we = 1'b1;
					sl_we = 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (iv_we) iv_mem[wa] <= iv_wd;
		if (rd_en) iv_s1 <= iv_mem[rd_q];
	end

	always_ff @(posedge clk) begin
		if (wt_we) wt_mem[wa] <= wt_wd;
		if (rd_en) wt_s1 <= wt_mem[rd_q];
	end

	always_ff @(posedge clk) begin
		if (sl_we) sl_mem[wa] <= sl_wd;
		if (rd_en) sl_s1 <= sl_mem[rd_q];
	end

	always_ff @(posedge clk) begin
		if (ctl.load) req_q <= request;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q      <= '0;
			scan_q       <= '0;
			ticks_q      <= '0;
			rd_q         <= '0;
			rem_q        <= '0;
			v_s1         <= 1'b0;
			addr_s1      <= '0;
			res_status_q <= ST_OK;
			res_disp_q   <= 1'b0;
			res_index_q  <= '0;
			res_woke_q   <= 1'b0;
		end else begin
			if (ctl.init) begin
				v_s1 <= 1'b0;
				case (req_q.func)
					FN_TICK: begin
						rd_q  <= '0;
						rem_q <= total_q;
					end
					FN_POLL: begin
						rd_q  <= scan_start;
						rem_q <= total_q;
					end
					FN_REMOVE: begin
						rd_q  <= IW'(req_q.task_index) + 1'b1;
						rem_q <= CW'(total_c - idx_c - CMPW'(1));
					end
					default: rem_q <= '0;
				endcase
			end

			if (ctl.run) begin
				v_s1 <= rd_en;
				if (rd_en) begin
					addr_s1 <= rd_q;
					rd_q    <= rd_nxt;
					rem_q   <= rem_q - 1'b1;
				end
				if (hit) begin
					scan_q       <= scan_hit;
					res_status_q <= ST_OK;
					res_disp_q   <= 1'b1;
					res_index_q  <= 4'(addr_s1);
					res_woke_q   <= sl_s1 != '0;
				end else if (drained) begin
					res_disp_q  <= 1'b0;
					res_index_q <= '0;
					res_woke_q  <= 1'b0;
					case (req_q.func)
						FN_TICK: begin
							ticks_q      <= ticks_q + 1'b1;
							res_status_q <= ST_OK;
						end
						FN_POLL: res_status_q <= ST_NONE_DUE;
						FN_REMOVE: begin
							total_q      <= tot_m1;
							scan_q       <= (CMPW'(scan_dec) >= CMPW'(tot_m1)) ? '0 : scan_dec;
							res_status_q <= ST_OK;
						end
						default: res_status_q <= ST_OK;
					endcase
				end
			end

			if (ctl.apply) begin
				res_disp_q  <= 1'b0;
				res_index_q <= '0;
				res_woke_q  <= 1'b0;
				case (req_q.func)
					FN_ADD: begin
						if (full) begin
							res_status_q <= ST_FULL;
						end else begin
							total_q      <= total_q + 1'b1;
							res_index_q  <= 4'(total_q);
							res_status_q <= ST_OK;
						end
					end
					FN_RESET, FN_REMOVE, FN_SLEEP: begin
						res_status_q <= idx_bad ? ST_BAD_INDEX : ST_OK;
					end
					default: res_status_q <= ST_OK;
				endcase
			end
		end
	end

	always_comb begin
		result.status          = res_status_q;
		result.dispatched      = res_disp_q;
		result.run_index       = res_index_q;
		result.woke_from_sleep = res_woke_q;
		result.task_total      = 5'(total_q);
		result.elapsed_ticks   = ticks_q;
	end

endmodule

@@ rtl/core/periodic_task_dispatcher_top.sv @@
// channel   | handshake          | payload
// ----------+--------------------+-------------------------------
// request   | start, busy        | request (func, task_index, tick_count)
// result    | done (one cycle)   | result (status ... elapsed_ticks)
//
// add, reset timer, sleep, unused codes and bad-index requests: applied without a sweep
// tick: sweeps every task; poll: sweeps from the scan position until a due task
// remove: sweeps the tasks after the index, moving each down one slot
// the sweeps walk the task table through its single read and single write port
// arst_n clears counts and scan position; the tables need no clearing pass
// start is ignored while busy; the receiver cannot stall, done lasts one cycle
module periodic_task_dispatcher_top
	import ptd_pkg::*;
#(
	parameter int MAX_TASKS  = MAX_TASKS_DEF,
	parameter int TICK_WIDTH = TICK_WIDTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  ptd_in_t  request,
	output logic     done,
	output ptd_out_t result
);

	ptd_ctl_t ctl;
	ptd_sts_t sts;

	ptd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	ptd_dp #(
		.MAX_TASKS  (MAX_TASKS),
		.TICK_WIDTH (TICK_WIDTH)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.ctl     (ctl),
		.sts     (sts),
		.result  (result)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted without going busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_disp_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.dispatched |-> result.status == ST_OK)
		else $error("dispatch reported with error status");

endmodule

@@ sim/ptd_result_checker.sv @@
`timescale 1ns / 100ps

module ptd_result_checker
	import ptd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  ptd_in_t  request,
	input  logic     done,
	input  ptd_out_t result,
	output int       fail_count,
	output int       waiting,
	output int       dispatch_count,
	output int       wake_count
);

	localparam int SLOTS = MAX_TASKS_DEF;
	localparam logic [TICK_WIDTH_DEF-1:0] WAIT_TOP = '1;

	logic [14:0]               interval_tbl [SLOTS];
	logic [TICK_WIDTH_DEF-1:0] waited_tbl   [SLOTS];
	logic [14:0]               sleep_tbl    [SLOTS];
	int unsigned               held;
	int unsigned               scan;
	logic [31:0]               ticks;
	ptd_out_t                  expected_results [$];

	function automatic ptd_out_t predict_outcome(input ptd_in_t req);
		ptd_out_t    res;
		int unsigned pos;
		int unsigned idx;
		bit          found;
		res = '0;
		found = 1'b0;
		idx = req.task_index;
		case (req.func)
			FN_TICK: begin
				for (int i = 0; i < held; i++)
					if (waited_tbl[i] != WAIT_TOP)
						waited_tbl[i] = waited_tbl[i] + 1'b1;
				ticks = ticks + 1;
			end
			FN_ADD: begin
				if (held >= SLOTS) begin
					res.status = ST_FULL;
				end else begin
					interval_tbl[held] = req.tick_count;
					waited_tbl[held] = '0;
					sleep_tbl[held] = '0;
					res.run_index = 4'(held);
					held++;
				end
			end
			FN_RESET: begin
				if (idx >= held)
					res.status = ST_BAD_INDEX;
				else
					waited_tbl[idx] = '0;
			end
			FN_POLL: begin
				pos = (scan < held) ? scan : 0;
				for (int i = 0; i < held; i++) begin
					if (!found && waited_tbl[pos] >= sleep_tbl[pos]
							&& waited_tbl[pos] >= interval_tbl[pos]) begin
						found = 1'b1;
						res.dispatched = 1'b1;
						res.run_index = 4'(pos);
						res.woke_from_sleep = (sleep_tbl[pos] != '0);
						waited_tbl[pos] = '0;
						sleep_tbl[pos] = '0;
						scan = (pos + 1 < held) ? pos + 1 : 0;
					end
					pos = (pos + 1 < held) ? pos + 1 : 0;
				end
				if (!found)
					res.status = ST_NONE_DUE;
			end
			FN_REMOVE: begin
				if (idx >= held) begin
					res.status = ST_BAD_INDEX;
				end else begin
					for (int i = idx; i + 1 < held; i++) begin
						interval_tbl[i] = interval_tbl[i + 1];
						waited_tbl[i] = waited_tbl[i + 1];
						sleep_tbl[i] = sleep_tbl[i + 1];
					end
					held--;
					if (scan > idx)
						scan--;
					if (scan >= held)
						scan = 0;
				end
			end
			FN_SLEEP: begin
				if (idx >= held) begin
					res.status = ST_BAD_INDEX;
				end else begin
					waited_tbl[idx] = '0;
					sleep_tbl[idx] = req.tick_count;
				end
			end
			default: ;
		endcase
		res.task_total = 5'(held);
		res.elapsed_ticks = ticks;
		return res;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		ptd_out_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				interval_tbl[i] = '0;
				waited_tbl[i] = '0;
				sleep_tbl[i] = '0;
			end
			held = 0;
			scan = 0;
			ticks = '0;
			expected_results.delete();
			fail_count = 0;
			dispatch_count = 0;
			wake_count = 0;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					$error("result with no request outstanding");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", want.status, result.status);
					check_field("dispatched", want.dispatched, result.dispatched);
					check_field("run_index", want.run_index, result.run_index);
					check_field("woke_from_sleep", want.woke_from_sleep,
						result.woke_from_sleep);
					check_field("task_total", want.task_total, result.task_total);
					check_field("elapsed_ticks", want.elapsed_ticks, result.elapsed_ticks);
					dispatch_count += want.dispatched;
					wake_count += want.woke_from_sleep;
				end
			end
			if (start && !busy)
				expected_results.push_back(predict_outcome(request));
		end
		waiting = expected_results.size();
	end

endmodule

@@ sim/tb_periodic_task_dispatcher_top.sv @@
`timescale 1ns / 100ps

module tb_periodic_task_dispatcher_top;
	import ptd_pkg::*;

	localparam int SLOTS = MAX_TASKS_DEF;

	logic     clk;
	logic     arst_n;
	logic     start;
	logic     busy;
	ptd_in_t  request;
	logic     done;
	ptd_out_t result;

	int fail_count;
	int waiting;
	int dispatch_count;
	int wake_count;

	int tasks_held;
	bit no_gaps;
	int sent_by_func [8];
	int sent_total;

	periodic_task_dispatcher_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	ptd_result_checker results_watch (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.request        (request),
		.done           (done),
		.result         (result),
		.fail_count     (fail_count),
		.waiting        (waiting),
		.dispatch_count (dispatch_count),
		.wake_count     (wake_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic ptd_in_t make_req(input logic [2:0] fn, input logic [3:0] idx,
			input logic [14:0] cnt);
		ptd_in_t req;
		req.func = fn;
		req.task_index = idx;
		req.tick_count = cnt;
		return req;
	endfunction

	// table size drifts with the bias: 0 mild growth, 1 grow, 2 shrink
	function automatic ptd_in_t random_req(input int bias);
		ptd_in_t req;
		int      add_w;
		int      rem_w;
		int      pick;
		add_w = (bias == 1) ? 30 : (bias == 2) ? 5 : 12;
		rem_w = (bias == 1) ? 4 : (bias == 2) ? 25 : 8;
		req = ptd_in_t'($urandom);
		pick = $urandom_range(0, 74 + add_w + rem_w);
		if (pick < 34)
			req.func = FN_TICK;
		else if (pick < 58)
			req.func = FN_POLL;
		else if (pick < 64)
			req.func = FN_RESET;
		else if (pick < 72)
			req.func = FN_SLEEP;
		else if (pick < 75)
			req.func = 3'($urandom_range(FN_SLEEP + 1, 7));
		else if (pick < 75 + add_w)
			req.func = FN_ADD;
		else
			req.func = FN_REMOVE;
		if (tasks_held > 0 && $urandom_range(0, 9) != 0)
			req.task_index = 4'($urandom_range(0, tasks_held - 1));
		if ($urandom_range(0, 9) != 0)
			req.tick_count = 15'($urandom_range(0, 14));
		return req;
	endfunction

	task automatic issue_request(input ptd_in_t req);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		request <= req;
		do @(posedge clk); while (busy);
		if (req.func == FN_ADD && tasks_held < SLOTS)
			tasks_held++;
		if (req.func == FN_REMOVE && req.task_index < tasks_held)
			tasks_held--;
		sent_by_func[req.func]++;
		sent_total++;
	endtask

	task automatic wait_until_drained();
		start <= 1'b0;
		do @(negedge clk); while (waiting != 0);
		@(posedge clk);
	endtask

	initial begin
		int bias;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		tasks_held = 0;
		no_gaps = 1'b0;
		sent_total = 0;
		foreach (sent_by_func[i])
			sent_by_func[i] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table corners, then a few tasks, sleeps and removals
		issue_request(make_req(FN_POLL, 4'd0, 15'd0));
		issue_request(make_req(FN_TICK, 4'd15, 15'h7fff));
		issue_request(make_req(FN_REMOVE, 4'd0, 15'd0));
		issue_request(make_req(FN_RESET, 4'd15, 15'd0));
		issue_request(make_req(FN_SLEEP, 4'd3, 15'd5));
		issue_request(make_req(FN_ADD, 4'd0, 15'd0));
		issue_request(make_req(FN_ADD, 4'd15, 15'h7fff));
		issue_request(make_req(FN_ADD, 4'd0, 15'd2));
		issue_request(make_req(FN_POLL, 4'd0, 15'd0));
		issue_request(make_req(FN_POLL, 4'd0, 15'd0));
		issue_request(make_req(FN_SLEEP, 4'd0, 15'd3));
		issue_request(make_req(FN_TICK, 4'd0, 15'd0));
		issue_request(make_req(FN_TICK, 4'd0, 15'd0));
		issue_request(make_req(FN_POLL, 4'd0, 15'd0));
		issue_request(make_req(FN_TICK, 4'd0, 15'd0));
		issue_request(make_req(FN_POLL, 4'd0, 15'd0));
		issue_request(make_req(FN_POLL, 4'd0, 15'd0));
		issue_request(make_req(FN_RESET, 4'd2, 15'd0));
		issue_request(make_req(FN_REMOVE, 4'd1, 15'd0));
		issue_request(make_req(FN_REMOVE, 4'd2, 15'd0));
		issue_request(make_req(3'd6, 4'd9, 15'h5555));
		issue_request(make_req(3'd7, 4'd6, 15'h2aaa));
		issue_request(make_req(FN_SLEEP, 4'd1, 15'h7fff));
		issue_request(make_req(FN_POLL, 4'd0, 15'd0));
		wait_until_drained();

		for (int blk = 0; blk < 8; blk++) begin
			bias = (blk < 2) ? 1 : $urandom_range(0, 2);
			no_gaps = ($urandom_range(0, 3) == 0);
			repeat (100)
				issue_request(random_req(bias));
			if (blk == 3 || $urandom_range(0, 1) == 0)
				wait_until_drained();
		end
		no_gaps = 1'b0;

		wait_until_drained();
		repeat (40) @(posedge clk);
		$display("covered %0d requests: %0d ticks, %0d adds, %0d timer resets, %0d polls,",
			sent_total, sent_by_func[FN_TICK], sent_by_func[FN_ADD],
			sent_by_func[FN_RESET], sent_by_func[FN_POLL]);
		$display("  %0d removes, %0d sleeps; %0d dispatches, %0d of them waking from sleep",
			sent_by_func[FN_REMOVE], sent_by_func[FN_SLEEP], dispatch_count, wake_count);
		if (fail_count == 0 && waiting == 0)
			$display("periodic_task_dispatcher_top: match");
		else
			$display("periodic_task_dispatcher_top: mismatch");
		$finish;
	end

	initial begin
		#4_000_000;
		$display("periodic_task_dispatcher_top: mismatch");
		$finish;
	end

endmodule
